/* rtl/core/bfsa_pkg.sv */
package bfsa_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int ADDR_BITS_DEF    = 32;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_MAP   = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic REG_MEMORY_SIZE = 1'b0;
	localparam logic REG_ATOM_LOG2   = 1'b1;

	localparam logic [31:0] MEMORY_SIZE_RESET = 32'd65536;
	localparam logic [4:0]  ATOM_LOG2_RESET   = 5'd6;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] buffer_id;
		logic [31:0] request_size;
		logic [4:0]  align_log2;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] bound_offset;
		logic [31:0] range_offset;
		logic [31:0] range_size;
		logic [31:0] pointer_offset;
	} rsp_t;

	// commands broadcast from the controller to every cell
	typedef struct packed {
		logic init;       // load reset table
		logic wr_sel;     // write selected cell
		logic ins_right;  // cells above idx take left neighbor
		logic del_at;     // cells at or above idx take right neighbor
		logic grow_left;  // cell idx-1 adds length of cell idx
	} cell_cmd_t;

endpackage

/* rtl/core/best_fit_segment_allocator_top.sv */
// Best-fit segment allocator.
// Command channel: drive req with start high; the request is taken at an edge
// where start is high and busy is low. busy stays high until the result.
// The result is held on rsp and flagged by done for exactly one cycle; the
// receiver must take it then, it cannot stall the block.
// Configuration: cfg_we, cfg_index, cfg_data. Index 0 sets memory size and
// reinitializes the table to one free segment; index 1 sets atom log2.
// Write only while idle.
// Allocate scans every entry and keeps the free fit that leaves the least
// remainder (first on a tie), then fails (no fit, full), takes it whole, or
// splits it; free scans to the owner's entry, marks it free and merges free
// neighbors; map scans to the owner's entry and returns its atom-aligned range;
// unused mode skips the scan. The scan walks the chain one entry a cycle.
// One request at a time: the next one is taken at the edge ending the done
// cycle.
// Reset: table is one free segment of 65536 bytes, atom 64 bytes.
module best_fit_segment_allocator_top
	import bfsa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int AW = ADDR_BITS;

	logic [AW-1:0] mem_size_q;
	logic [4:0]    atom_q;
	logic          cfg_init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= AW'(MEMORY_SIZE_RESET);
			atom_q     <= ATOM_LOG2_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_MEMORY_SIZE)
				mem_size_q <= AW'({{(AW > 32 ? AW-32 : 1){1'b0}}, cfg_data});
			else
				atom_q <= cfg_data[4:0];
		end
	end
	assign cfg_init = cfg_we && cfg_index == REG_MEMORY_SIZE;

	logic [AW-1:0] c_start [MAX_SEGMENTS+1];
	logic [AW-1:0] c_len   [MAX_SEGMENTS+1];
	logic          c_free  [MAX_SEGMENTS+1];
	logic [15:0]   c_owner [MAX_SEGMENTS+1];
	logic [AW-1:0] c_bst   [MAX_SEGMENTS+1];

	cell_cmd_t     cmd;
	logic [IW-1:0] scan_idx, tgt_idx, tgt_s1;
	logic [AW-1:0] wr_start, wr_len, wr_bstart;
	logic          wr_free;
	logic [15:0]   wr_owner;
	cell_cmd_t     cmd_now;
	logic          wr_en;

	// cell write of the selected entry is immediate; shifts use registered cmd
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tgt_s1 <= '0;
		else
			tgt_s1 <= tgt_idx;
	end

	assign c_start[MAX_SEGMENTS] = '0;
	assign c_len[MAX_SEGMENTS]   = '0;
	assign c_free[MAX_SEGMENTS]  = 1'b0;
	assign c_owner[MAX_SEGMENTS] = '0;
	assign c_bst[MAX_SEGMENTS]   = '0;

	bfsa_ctrl #(.NSEG(MAX_SEGMENTS), .AW(AW)) u_ctrl (
		.clk, .arst_n, .start, .busy, .req,
		.cfg_init, .mem_size(mem_size_q), .atom_log2(atom_q),
		.scan_idx,
		.s_start(c_start[scan_idx]), .s_len(c_len[scan_idx]),
		.s_free(c_free[scan_idx]), .s_owner(c_owner[scan_idx]),
		.s_bstart(c_bst[scan_idx]),
		.cmd, .tgt_idx, .wr_sel(wr_en),
		.wr_start, .wr_len, .wr_free, .wr_owner, .wr_bstart,
		.done, .rsp
	);

	always_comb begin
		cmd_now        = cmd;
		cmd_now.wr_sel = wr_en;
	end

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		logic [IW:0] gi;
		assign gi = (IW+1)'(g);
		bfsa_cell #(.AW(AW), .IS_FIRST(g == 0)) u_cell (
			.clk, .arst_n, .cmd(cmd_now),
			.sel(gi == {1'b0, tgt_idx}),
			.above(gi > {1'b0, tgt_s1}),
			.at_or_above(gi >= {1'b0, tgt_s1}),
			.is_left(gi + 1'b1 == {1'b0, tgt_s1}),
			.init_len(mem_size_q),
			.wr_start, .wr_len, .wr_free, .wr_owner, .wr_bstart,
			.l_start(c_start[g == 0 ? 0 : g-1]), .l_len(c_len[g == 0 ? 0 : g-1]),
			.l_free(c_free[g == 0 ? 0 : g-1]), .l_owner(c_owner[g == 0 ? 0 : g-1]),
			.l_bstart(c_bst[g == 0 ? 0 : g-1]),
			.r_start(c_start[g+1]), .r_len(c_len[g+1]),
			.r_free(c_free[g+1]), .r_owner(c_owner[g+1]), .r_bstart(c_bst[g+1]),
			.start(c_start[g]), .len(c_len[g]), .free(c_free[g]),
			.owner(c_owner[g]), .bstart(c_bst[g])
		);
	end

endmodule

/* rtl/core/bfsa_cell.sv */
module bfsa_cell
	import bfsa_pkg::*;
#(
	parameter int AW = ADDR_BITS_DEF,
	parameter bit IS_FIRST = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic          sel,       // this cell is the target index
	input  logic          above,     // index greater than target
	input  logic          at_or_above,
	input  logic          is_left,   // index == target-1
	input  logic [AW-1:0] init_len,
	input  logic [AW-1:0] wr_start,
	input  logic [AW-1:0] wr_len,
	input  logic          wr_free,
	input  logic [15:0]   wr_owner,
	input  logic [AW-1:0] wr_bstart,
	input  logic [AW-1:0] l_start,
	input  logic [AW-1:0] l_len,
	input  logic          l_free,
	input  logic [15:0]   l_owner,
	input  logic [AW-1:0] l_bstart,
	input  logic [AW-1:0] r_start,
	input  logic [AW-1:0] r_len,
	input  logic          r_free,
	input  logic [15:0]   r_owner,
	input  logic [AW-1:0] r_bstart,
	output logic [AW-1:0] start,
	output logic [AW-1:0] len,
	output logic          free,
	output logic [15:0]   owner,
	output logic [AW-1:0] bstart
);

	logic [AW-1:0] start_q, len_q, bstart_q;
	logic          free_q;
	logic [15:0]   owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			len_q    <= IS_FIRST ? AW'(MEMORY_SIZE_RESET) : '0;
			free_q   <= IS_FIRST;
			owner_q  <= '0;
			bstart_q <= '0;
		end else if (cmd.init) begin
			start_q <= '0;
			len_q   <= IS_FIRST ? init_len : '0;
			free_q  <= IS_FIRST;
		end else if (cmd.ins_right && above) begin
			start_q  <= l_start;
			len_q    <= l_len;
			free_q   <= l_free;
			owner_q  <= l_owner;
			bstart_q <= l_bstart;
		end else if (cmd.del_at && at_or_above) begin
			start_q  <= r_start;
			len_q    <= r_len;
			free_q   <= r_free;
			owner_q  <= r_owner;
			bstart_q <= r_bstart;
		end else if (cmd.grow_left && is_left) begin
			len_q <= len_q + r_len;
		end else if (cmd.wr_sel && sel) begin
			start_q  <= wr_start;
			len_q    <= wr_len;
			free_q   <= wr_free;
			owner_q  <= wr_owner;
			bstart_q <= wr_bstart;
		end
	end

	assign start  = start_q;
	assign len    = len_q;
	assign free   = free_q;
	assign owner  = owner_q;
	assign bstart = bstart_q;

endmodule

/* rtl/core/bfsa_ctrl.sv */
module bfsa_ctrl
	import bfsa_pkg::*;
#(
	parameter int NSEG = MAX_SEGMENTS_DEF,
	parameter int AW   = ADDR_BITS_DEF,
	localparam int IW  = $clog2(NSEG),
	localparam int CW  = $clog2(NSEG + 1),
	localparam int XW  = (AW > 32 ? AW : 32) + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  req_t          req,
	input  logic          cfg_init,
	input  logic [AW-1:0] mem_size,
	input  logic [4:0]    atom_log2,
	// scanned entry
	output logic [IW-1:0] scan_idx,
	input  logic [AW-1:0] s_start,
	input  logic [AW-1:0] s_len,
	input  logic          s_free,
	input  logic [15:0]   s_owner,
	input  logic [AW-1:0] s_bstart,
	output cell_cmd_t     cmd,
	output logic [IW-1:0] tgt_idx,
	output logic          wr_sel,
	output logic [AW-1:0] wr_start,
	output logic [AW-1:0] wr_len,
	output logic          wr_free,
	output logic [15:0]   wr_owner,
	output logic [AW-1:0] wr_bstart,
	output logic          done,
	output rsp_t          rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_INS, S_INS_WR, S_OWN,
		S_FREE_L, S_FREE_R, S_FREE_R2, S_MAP1, S_MAP2
	} state_t;

	state_t        state_q;
	req_t          req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q;
	logic          found_q;
	logic [IW-1:0] best_q;
	logic [XW-1:0] left_q;
	logic [AW-1:0] occ_q, pos_q, bstart_q, sstart_q, slen_q;
	logic          done_q;
	rsp_t          rsp_q;
	logic [AW-1:0] lo_q, span_q;

	// per-entry fit check
	logic [XW-1:0] amask, pos_w, pad_w, left_w, occ_w, req_w, len_w;
	logic          fits;
	logic [XW-1:0] at_mask, up_w, room_w;

	always_comb begin
		req_w   = XW'(req_q.request_size);
		len_w   = XW'(s_len);
		amask   = (XW'(1) << req_q.align_log2) - XW'(1);
		pos_w   = (XW'(s_start) + amask) & ~amask;
		pad_w   = pos_w - XW'(s_start);
		occ_w   = pad_w + req_w;
		left_w  = len_w - occ_w;
		fits    = s_free && (pad_w <= len_w) && (len_w - pad_w >= req_w);
		at_mask = (XW'(1) << atom_log2) - XW'(1);
		up_w    = (XW'(span_q) + at_mask) & ~at_mask;
		room_w  = (mem_size > lo_q) ? XW'(mem_size - lo_q) : '0;
	end

	assign scan_idx = i_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			count_q  <= CW'(1);
			i_q      <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			left_q   <= '0;
			occ_q    <= '0;
			pos_q    <= '0;
			bstart_q <= '0;
			sstart_q <= '0;
			slen_q   <= '0;
			lo_q     <= '0;
			span_q   <= '0;
			rsp_q    <= '0;
			done_q   <= 1'b0;
			cmd      <= '0;
		end else begin
			done_q <= 1'b0;
			cmd    <= '0;
			if (cfg_init) begin
				cmd.init <= 1'b1;
				count_q  <= CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						i_q     <= '0;
						found_q <= 1'b0;
						state_q <= (req.mode inside {MODE_ALLOC, MODE_FREE, MODE_MAP})
							? S_SCAN : S_DECIDE;
					end
				end
				S_SCAN: begin
					if (i_q >= count_q) begin
						state_q <= S_DECIDE;
					end else if (req_q.mode == MODE_ALLOC) begin
						i_q <= i_q + 1'b1;
						if (fits && (!found_q || left_w < left_q)) begin
							found_q  <= 1'b1;
							best_q   <= i_q[IW-1:0];
							left_q   <= left_w;
							occ_q    <= occ_w[AW-1:0];
							pos_q    <= pos_w[AW-1:0];
							sstart_q <= s_start;
						end
					end else if (!s_free && s_owner == req_q.buffer_id) begin
						found_q  <= 1'b1;
						best_q   <= i_q[IW-1:0];
						sstart_q <= s_start;
						slen_q   <= s_len;
						bstart_q <= s_bstart;
						i_q      <= count_q;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_DECIDE: begin
					rsp_q   <= '0;
					state_q <= S_IDLE;
					if (req_q.mode == MODE_ALLOC) begin
						if (!found_q) begin
							rsp_q.status <= ST_NO_FIT;
							done_q       <= 1'b1;
						end else if (left_q != '0 && count_q >= CW'(NSEG)) begin
							rsp_q.status <= ST_FULL;
							done_q       <= 1'b1;
						end else if (left_q != '0) begin
							cmd.ins_right <= 1'b1;
							state_q       <= S_INS;
						end else begin
							state_q <= S_OWN;
						end
					end else if (req_q.mode == MODE_FREE || req_q.mode == MODE_MAP) begin
						if (!found_q) begin
							rsp_q.status <= ST_NOT_FOUND;
							done_q       <= 1'b1;
						end else if (req_q.mode == MODE_FREE) begin
							state_q <= S_FREE_L;
						end else begin
							lo_q    <= sstart_q & ~at_mask[AW-1:0];
							state_q <= S_MAP1;
						end
					end else begin
						done_q <= 1'b1;
					end
				end
				S_INS: begin
					// best+1 takes the copy of best as this state ends; S_INS_WR overwrites it with remainder
					count_q <= count_q + 1'b1;
					best_q  <= best_q + 1'b1;
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					best_q  <= best_q - 1'b1;
					state_q <= S_OWN;
				end
				S_OWN: begin
					rsp_q.bound_offset <= 32'(pos_q);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FREE_L: begin
					// cell free write happens via wr_sel in this state; check left neighbor
					i_q     <= CW'(best_q) - 1'b1;
					state_q <= S_FREE_R;
				end
				S_FREE_R: begin
					if (best_q != '0 && s_free) begin
						cmd.grow_left <= 1'b1;
						cmd.del_at    <= 1'b1;
						count_q       <= count_q - 1'b1;
						best_q        <= best_q - 1'b1;
					end
					state_q <= S_FREE_R2;
				end
				S_FREE_R2: begin
					i_q <= CW'(best_q) + 1'b1;
					if (i_q == CW'(best_q) + 1'b1) begin
						// right neighbor at i_q folds into best_q
						if (i_q < count_q && s_free) begin
							cmd.grow_left <= 1'b1;
							cmd.del_at    <= 1'b1;
							count_q       <= count_q - 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MAP1: begin
					span_q  <= slen_q + (sstart_q - lo_q);
					state_q <= S_MAP2;
				end
				S_MAP2: begin
					rsp_q.range_offset   <= 32'(lo_q);
					rsp_q.range_size     <= 32'((up_w < room_w) ? up_w : room_w);
					rsp_q.pointer_offset <= 32'(bstart_q - lo_q);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// combinational write data and target index for the selected cell
	always_comb begin
		wr_start  = s_start;
		wr_len    = s_len;
		wr_free   = s_free;
		wr_owner  = s_owner;
		wr_bstart = s_bstart;
		tgt_idx   = (state_q == S_FREE_R2) ? i_q[IW-1:0] : best_q;
		if (state_q == S_INS_WR) begin
			wr_start  = sstart_q + occ_q;
			wr_len    = left_q[AW-1:0];
			wr_free   = 1'b1;
			wr_owner  = '0;
			wr_bstart = '0;
		end else if (state_q == S_OWN) begin
			wr_start  = sstart_q;
			wr_len    = occ_q;
			wr_free   = 1'b0;
			wr_owner  = req_q.buffer_id;
			wr_bstart = pos_q;
		end else if (state_q == S_FREE_L) begin
			wr_start  = sstart_q;
			wr_len    = slen_q;
			wr_free   = 1'b1;
			wr_owner  = req_q.buffer_id;
			wr_bstart = bstart_q;
		end
	end

	// grow/del timing: cmd is registered, so the cell array sees tgt_idx from
	// the cycle that issued the command
	assign wr_sel = state_q inside {S_INS_WR, S_OWN, S_FREE_L};

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* rtl/core/bfsa_checker.sv */
module bfsa_checker
	import bfsa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than a cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.bound_offset == '0 && rsp.range_size == '0)
		else $error("failed request carries data");

endmodule

bind best_fit_segment_allocator_top bfsa_checker u_bfsa_checker (
	.clk, .arst_n, .start, .busy, .done, .rsp
);

/* dv/best_fit_segment_allocator_top_test.sv */
module best_fit_segment_allocator_top_test;
	import bfsa_pkg::*;

	localparam int SEGS = MAX_SEGMENTS_DEF;
	localparam int DRAIN_CYCLES = 2 * SEGS + 12;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	best_fit_segment_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mirror of the segment table
	bit [63:0] mem_bytes;
	bit [63:0] atom_log2;
	bit [63:0] seg_base [SEGS];
	bit [63:0] seg_len [SEGS];
	bit        seg_open [SEGS];
	bit [15:0] seg_owner [SEGS];
	bit [63:0] seg_ptr [SEGS];
	int        seg_cnt;

	rsp_t expected_rsp [$];
	int   errors = 0;
	int   cycles = 0;
	int   burst_left = 0;
	int   burst_gap = 0;

	function automatic void table_clear();
		for (int i = 0; i < SEGS; i++) begin
			seg_base[i] = 0;
			seg_len[i] = 0;
			seg_open[i] = 0;
			seg_owner[i] = 0;
			seg_ptr[i] = 0;
		end
		seg_len[0] = mem_bytes;
		seg_open[0] = 1;
		seg_cnt = 1;
	endfunction

	function automatic void copy_seg(int dst, int src);
		seg_base[dst] = seg_base[src];
		seg_len[dst] = seg_len[src];
		seg_open[dst] = seg_open[src];
		seg_owner[dst] = seg_owner[src];
		seg_ptr[dst] = seg_ptr[src];
	endfunction

	function automatic void fold_left(int k);
		seg_len[k - 1] += seg_len[k];
		for (int i = k; i + 1 < seg_cnt; i++)
			copy_seg(i, i + 1);
		seg_cnt--;
	endfunction

	function automatic int owner_slot(bit [15:0] id);
		for (int i = 0; i < seg_cnt; i++)
			if (!seg_open[i] && seg_owner[i] == id)
				return i;
		return seg_cnt;
	endfunction

	// applies one request to the mirror and returns the expected response
	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		bit [63:0] a, s, len, pos, pad, occ, left, best_left, best_occ, best_pos;
		bit [63:0] at, lo, span, up, room, sz;
		int best, k;
		o = '0;
		sz = 64'(r.request_size);
		if (r.mode == MODE_ALLOC) begin
			a = 64'd1 << r.align_log2;
			best = seg_cnt;
			best_left = 0;
			best_occ = 0;
			best_pos = 0;
			for (int i = 0; i < seg_cnt; i++) begin
				if (!seg_open[i])
					continue;
				s = seg_base[i];
				len = seg_len[i];
				pos = (s + a - 1) & ~(a - 1);
				pad = pos - s;
				if (pad > len || len - pad < sz)
					continue;
				occ = pad + sz;
				left = len - occ;
				if (best == seg_cnt || left < best_left) begin
					best = i;
					best_left = left;
					best_occ = occ;
					best_pos = pos;
				end
			end
			if (best == seg_cnt) begin
				o.status = ST_NO_FIT;
			end else if (best_left != 0 && seg_cnt >= SEGS) begin
				o.status = ST_FULL;
			end else begin
				if (best_left != 0) begin
					for (int i = seg_cnt; i > best + 1; i--)
						copy_seg(i, i - 1);
					seg_base[best + 1] = seg_base[best] + best_occ;
					seg_len[best + 1] = best_left;
					seg_open[best + 1] = 1;
					seg_owner[best + 1] = 0;
					seg_ptr[best + 1] = 0;
					seg_cnt++;
				end
				seg_len[best] = best_occ;
				seg_open[best] = 0;
				seg_owner[best] = r.buffer_id;
				seg_ptr[best] = best_pos;
				o.bound_offset = best_pos[31:0];
			end
		end else if (r.mode == MODE_FREE) begin
			k = owner_slot(r.buffer_id);
			if (k == seg_cnt) begin
				o.status = ST_NOT_FOUND;
			end else begin
				seg_open[k] = 1;
				if (k > 0 && seg_open[k - 1]) begin
					fold_left(k);
					k--;
				end
				if (k + 1 < seg_cnt && seg_open[k + 1])
					fold_left(k + 1);
			end
		end else if (r.mode == MODE_MAP) begin
			k = owner_slot(r.buffer_id);
			if (k == seg_cnt) begin
				o.status = ST_NOT_FOUND;
			end else begin
				at = 64'd1 << atom_log2;
				s = seg_base[k];
				lo = s & ~(at - 1);
				span = seg_len[k] + (s - lo);
				up = (span + at - 1) & ~(at - 1);
				room = mem_bytes > lo ? mem_bytes - lo : 0;
				o.range_offset = lo[31:0];
				o.range_size = up < room ? up[31:0] : room[31:0];
				o.pointer_offset = 32'(seg_ptr[k] - lo);
			end
		end
		return o;
	endfunction

	always @(posedge clk) begin
		rsp_t exp_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp);
				errors++;
			end else begin
				exp_r = expected_rsp.pop_front();
				if (rsp.status !== exp_r.status) begin
					$display("%0t: status exp %0d got %0d", $time, exp_r.status, rsp.status);
					errors++;
				end
				if (rsp.bound_offset !== exp_r.bound_offset) begin
					$display("%0t: bound_offset exp %h got %h", $time,
						exp_r.bound_offset, rsp.bound_offset);
					errors++;
				end
				if (rsp.range_offset !== exp_r.range_offset) begin
					$display("%0t: range_offset exp %h got %h", $time,
						exp_r.range_offset, rsp.range_offset);
					errors++;
				end
				if (rsp.range_size !== exp_r.range_size) begin
					$display("%0t: range_size exp %h got %h", $time,
						exp_r.range_size, rsp.range_size);
					errors++;
				end
				if (rsp.pointer_offset !== exp_r.pointer_offset) begin
					$display("%0t: pointer_offset exp %h got %h", $time,
						exp_r.pointer_offset, rsp.pointer_offset);
					errors++;
				end
			end
		end
	end

	// start stays high on return so back-to-back transfers need no extra edge
	task automatic send_req(logic [1:0] mode, logic [15:0] id, logic [31:0] sz,
			logic [4:0] alog);
		req_t r;
		r.mode = mode;
		r.buffer_id = id;
		r.request_size = sz;
		r.align_log2 = alog;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		expected_rsp.insert(expected_rsp.size(), serve_request(r));
	endtask

	task automatic hold_off(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		hold_off(1);
		while (expected_rsp.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MEMORY_SIZE) begin
			mem_bytes = 64'(val);
			table_clear();
		end else begin
			atom_log2 = 64'(val[4:0]);
		end
	endtask

	task automatic test_basic_modes();
		send_req(MODE_MAP, 16'd5, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd5, 32'd0, 5'd0);
		send_req(MODE_RSVD, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
		send_req(MODE_ALLOC, 16'd1, 32'd0, 5'd0);
		send_req(MODE_ALLOC, 16'd2, 32'd100, 5'd16);
		send_req(MODE_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
		send_req(MODE_MAP, 16'd2, 32'd0, 5'd0);
		send_req(MODE_ALLOC, 16'd2, 32'd64, 5'd3);
		send_req(MODE_ALLOC, 16'd3, 32'd7, 5'd1);
		send_req(MODE_MAP, 16'd2, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd2, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd2, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd1, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd3, 32'd0, 5'd0);
	endtask

	task automatic test_table_full();
		write_reg(REG_MEMORY_SIZE, 32'd64);
		write_reg(REG_ATOM_LOG2, 32'd5);
		for (int i = 0; i < SEGS; i++)
			send_req(MODE_ALLOC, 16'(10 + i), 32'd1, 5'd0);
		send_req(MODE_ALLOC, 16'd99, 32'd64 - 32'(SEGS - 1), 5'd0);
		send_req(MODE_MAP, 16'd99, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd12, 32'd0, 5'd0);
		send_req(MODE_FREE, 16'd11, 32'd0, 5'd0);
	endtask

	task automatic test_random(int n, int unsigned cap);
		logic [1:0]  mode;
		logic [15:0] id;
		logic [31:0] sz;
		logic [4:0]  alog;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			mode = pick < 45 ? MODE_ALLOC : pick < 70 ? MODE_FREE :
				pick < 95 ? MODE_MAP : MODE_RSVD;
			id = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 9));
			case ($urandom_range(0, 9))
				0: sz = $urandom;
				1: sz = 32'd0;
				default: sz = $urandom_range(1, cap);
			endcase
			alog = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 16))
				: 5'($urandom_range(0, 4));
			send_req(mode, id, sz, alog);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				burst_gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 15);
			end
			burst_left--;
			if (burst_left == 0 && burst_gap != 0)
				hold_off(burst_gap);
		end
	endtask

	initial begin
		mem_bytes = 64'(MEMORY_SIZE_RESET);
		atom_log2 = 64'(ATOM_LOG2_RESET);
		table_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_modes();
		test_table_full();
		write_reg(REG_MEMORY_SIZE, 32'd4096);
		write_reg(REG_ATOM_LOG2, 32'd4);
		test_random(250, 600);
		drain();
		test_random(50, 600);
		write_reg(REG_MEMORY_SIZE, 32'hFFFF_FFFF);
		write_reg(REG_ATOM_LOG2, 32'd16);
		test_random(200, 32'h3000_0000);
		write_reg(REG_MEMORY_SIZE, 32'd1);
		write_reg(REG_ATOM_LOG2, 32'd0);
		test_random(40, 1);
		write_reg(REG_MEMORY_SIZE, 32'd1000);
		write_reg(REG_ATOM_LOG2, 32'd9);
		test_random(200, 200);
		write_reg(REG_ATOM_LOG2, 32'd31);
		test_random(60, 200);
		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
